### rtl/nfb_pkg.sv
// Shared types, constants and the iteration micro-op table for the Newton basin core.
// Used by nfb_ctrl, nfb_datapath and the top level; depends on nothing else.
package nfb_pkg;

    // Default word format, signed Q8.24.
    localparam int WORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 24;

    // Fixed widths of the register port, of the result fields and of the micro-step counter.
    localparam int CFG_INDEX_W = 3;
    localparam int COUNT_W     = 10;
    localparam int UC_W        = 5;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ALPHA     = 3'd0,
        REG_ROOT_B_RE = 3'd1,
        REG_ROOT_B_IM = 3'd2,
        REG_ROOT_C_RE = 3'd3,
        REG_ROOT_C_IM = 3'd4,
        REG_HIT_RADIUS = 3'd5,
        REG_STEP_LIMIT = 3'd6
    } cfg_index_t;

    // Register values after reset.
    localparam logic [31:0]        ALPHA_RESET  = 32'h0000_0000;
    localparam logic [31:0]        ROOT_RESET   = 32'hFF80_0000;
    localparam logic [31:0]        ROOT_IM_RESET = 32'h0000_0000;
    localparam logic [31:0]        HIT_RESET    = 32'd17;
    localparam logic [COUNT_W-1:0] LIMIT_RESET  = 10'd100;

    // Result codes.
    localparam logic [1:0] ROOT_MINUS_ONE = 2'd0;
    localparam logic [1:0] ROOT_B         = 2'd1;
    localparam logic [1:0] ROOT_C         = 2'd2;
    localparam logic [1:0] ROOT_NONE      = 2'd3;

    // Micro-step positions inside the test and iteration sequences.
    localparam logic [UC_W-1:0] TEST_MUL_FR = 5'd0;
    localparam logic [UC_W-1:0] TEST_MUL_FI = 5'd1;
    localparam logic [UC_W-1:0] TEST_SUM    = 5'd2;
    localparam logic [UC_W-1:0] TEST_LAST   = 5'd3;
    localparam logic [UC_W-1:0] ITER_ZCHK   = 5'd14;
    localparam logic [UC_W-1:0] ITER_LAST   = 5'd20;

    // Operand pair fed to the shared multiplier.
    typedef enum logic [4:0] {
        M_NONE, M_FR_FR, M_FI_FI, M_ZR_ZR, M_ZI_ZI, M_ZR_ZI, M_ZI_ZR,
        M_W_Z2R, M_ZI_Z2I, M_W_Z2I, M_ZI_Z2R, M_UR_ZR, M_UI_ZI, M_UR_ZI,
        M_UI_ZR, M_DR_DR, M_DI_DI, M_NR_DR, M_NI_DI, M_NI_DR, M_NR_DI
    } mul_sel_t;

    // What is done with the product registered in the previous cycle.
    typedef enum logic [3:0] {
        P_NONE, P_LATCH_U, P_ACC_LD, P_ACC_ADD, P_MT, P_Z2R, P_Z2I, P_TR,
        P_TI, P_VR, P_VI_N, P_D, P_DEN, P_NUM_RE, P_NUM_IM
    } post_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        post_t    post;
    } uop_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        post_t    post;
        logic [1:0] root_sel;
        logic     div_start;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic               hit;
        logic               den_zero;
        logic               div_done;
        logic [COUNT_W-1:0] step_limit;
    } dp_stat_t;

    // One Newton step: z^2, (z+1)z^2, (3z+4)z, then |d|^2 and n*conj(d).
    function automatic uop_t iter_uop(input logic [UC_W-1:0] idx);
        uop_t u;
        u = '{mul_sel: M_NONE, post: P_NONE};
        case (idx)
            5'd0:  u = '{mul_sel: M_ZR_ZR,  post: P_LATCH_U};
            5'd1:  u = '{mul_sel: M_ZI_ZI,  post: P_MT};
            5'd2:  u = '{mul_sel: M_ZR_ZI,  post: P_Z2R};
            5'd3:  u = '{mul_sel: M_ZI_ZR,  post: P_MT};
            5'd4:  u = '{mul_sel: M_W_Z2R,  post: P_Z2I};
            5'd5:  u = '{mul_sel: M_ZI_Z2I, post: P_MT};
            5'd6:  u = '{mul_sel: M_W_Z2I,  post: P_TR};
            5'd7:  u = '{mul_sel: M_ZI_Z2R, post: P_MT};
            5'd8:  u = '{mul_sel: M_UR_ZR,  post: P_TI};
            5'd9:  u = '{mul_sel: M_UI_ZI,  post: P_MT};
            5'd10: u = '{mul_sel: M_UR_ZI,  post: P_VR};
            5'd11: u = '{mul_sel: M_UI_ZR,  post: P_MT};
            5'd12: u = '{mul_sel: M_NONE,   post: P_VI_N};
            5'd13: u = '{mul_sel: M_NONE,   post: P_D};
            5'd14: u = '{mul_sel: M_DR_DR,  post: P_NONE};
            5'd15: u = '{mul_sel: M_DI_DI,  post: P_ACC_LD};
            5'd16: u = '{mul_sel: M_NR_DR,  post: P_DEN};
            5'd17: u = '{mul_sel: M_NI_DI,  post: P_ACC_LD};
            5'd18: u = '{mul_sel: M_NI_DR,  post: P_NUM_RE};
            5'd19: u = '{mul_sel: M_NR_DI,  post: P_ACC_LD};
            5'd20: u = '{mul_sel: M_NONE,   post: P_NUM_IM};
            default: u = '{mul_sel: M_NONE, post: P_NONE};
        endcase
        return u;
    endfunction

endpackage

### rtl/nfb_div.sv
// Restoring divider: |num| * 2^FRAC_BITS / den with the sign of num, one quotient bit a cycle, saturated.
// Depends on nothing outside itself.
module nfb_div #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [2*WORD_WIDTH:0]  num,
    input  logic [2*WORD_WIDTH-1:0]       den,
    output logic                          done,
    output logic signed [WORD_WIDTH-1:0]  quo
);
    localparam int W    = WORD_WIDTH;
    localparam int CW   = 3 * W + FRAC_BITS + 1;
    localparam int CNTW = $clog2(W + 1);

    logic [CW-1:0]   rem_reg, rem_next;
    logic [CW-1:0]   dsh_reg, dsh_next;
    logic [W-1:0]    q_reg, q_next;
    logic            over_reg, over_next;
    logic            neg_reg, neg_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;

    logic [2*W:0]    num_mag;
    logic [CW-1:0]   dividend;
    logic            fits;
    logic [W-1:0]    lim;
    logic [W-1:0]    q_sat;

    // Operand set-up for a new division.
    assign num_mag  = num[2*W] ? (2*W+1)'(-num) : (2*W+1)'(num);
    assign dividend = CW'(num_mag) << FRAC_BITS;
    assign fits     = rem_reg >= dsh_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        over_next = over_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend;
            dsh_next  = CW'(den) << (W - 1);
            over_next = dividend >= (CW'(den) << W);
            neg_next  = num[2*W];
            q_next    = '0;
            cnt_next  = CNTW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // One quotient bit per cycle, most significant first.
            if (fits)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[W-2:0], fits};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        q_reg    <= q_next;
        over_reg <= over_next;
        neg_reg  <= neg_next;
    end

    // Saturate to the word range and apply the sign.
    assign lim   = neg_reg ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
    assign q_sat = (over_reg || q_reg > lim) ? lim : q_reg;
    assign quo   = neg_reg ? -q_sat : q_sat;
    assign done  = done_reg;

endmodule

### rtl/nfb_datapath.sv
// Datapath: configuration registers, shared multiplier, working registers, two dividers.
// Depends on nfb_pkg and nfb_div.
module nfb_datapath #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [nfb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [31:0]                         cfg_data,
    input  logic [31:0]                         start_re,
    input  logic [31:0]                         start_im,
    input  nfb_pkg::dp_cmd_t                    cmd,
    output nfb_pkg::dp_stat_t                   stat
);
    import nfb_pkg::*;

    localparam int W    = WORD_WIDTH;
    localparam int AW   = 2 * W + 1;
    localparam int CMPW = (2 * W > 32 + FRAC_BITS) ? 2 * W : 32 + FRAC_BITS;
    localparam logic signed [63:0] MAX64  = 64'sh7FFF_FFFF_FFFF_FFFF >>> (64 - W);
    localparam logic signed [63:0] MIN64  = ~MAX64;
    localparam logic signed [63:0] ONE64  = (FRAC_BITS >= W - 1) ? MAX64
                                            : (64'sd1 <<< FRAC_BITS);
    localparam logic signed [63:0] FOUR64 = (FRAC_BITS + 2 >= W - 1) ? MAX64
                                            : (64'sd4 <<< FRAC_BITS);
    localparam logic signed [W-1:0] MAX_W  = MAX64[W-1:0];
    localparam logic signed [W-1:0] MIN_W  = MIN64[W-1:0];
    localparam logic signed [W-1:0] ONE_W  = ONE64[W-1:0];
    localparam logic signed [W-1:0] FOUR_W = FOUR64[W-1:0];
    localparam logic signed [W-1:0] MONE_W = -ONE64[W-1:0];

    // Sign-extend a 32 bit register or input and clamp it to the word.
    function automatic logic signed [W-1:0] clamp32(input logic [31:0] v);
        logic signed [63:0] s;
        s = 64'(signed'(v));
        if (s > MAX64)
            return MAX_W;
        else if (s < MIN64)
            return MIN_W;
        return s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                     input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = (W+1)'(a) + (W+1)'(b);
        if (s[W] != s[W-1])
            return s[W] ? MIN_W : MAX_W;
        return s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                     input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = (W+1)'(a) - (W+1)'(b);
        if (s[W] != s[W-1])
            return s[W] ? MIN_W : MAX_W;
        return s[W-1:0];
    endfunction

    // Product truncated toward zero by FRAC_BITS, then saturated.
    function automatic logic signed [W-1:0] mulq(input logic signed [2*W-1:0] p);
        logic [2*W-1:0] m;
        logic [2*W-1:0] sh;
        logic [2*W-1:0] lim;
        logic [2*W-1:0] ms;
        m   = p[2*W-1] ? -p : p;
        sh  = m >> FRAC_BITS;
        lim = p[2*W-1] ? ((2*W)'(1) << (W - 1)) : (((2*W)'(1) << (W - 1)) - (2*W)'(1));
        ms  = (sh > lim) ? lim : sh;
        return p[2*W-1] ? -ms[W-1:0] : ms[W-1:0];
    endfunction

    // Configuration registers.
    logic [31:0]        alpha_reg, bre_reg, bim_reg, cre_reg, cim_reg, hit_reg;
    logic [COUNT_W-1:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
            bre_reg   <= ROOT_RESET;
            bim_reg   <= ROOT_IM_RESET;
            cre_reg   <= ROOT_RESET;
            cim_reg   <= ROOT_IM_RESET;
            hit_reg   <= HIT_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ALPHA:      alpha_reg <= cfg_data;
                REG_ROOT_B_RE:  bre_reg   <= cfg_data;
                REG_ROOT_B_IM:  bim_reg   <= cfg_data;
                REG_ROOT_C_RE:  cre_reg   <= cfg_data;
                REG_ROOT_C_IM:  cim_reg   <= cfg_data;
                REG_HIT_RADIUS: hit_reg   <= cfg_data;
                REG_STEP_LIMIT: limit_reg <= cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    logic signed [W-1:0] alpha_w;
    assign alpha_w = clamp32(alpha_reg);

    // Working registers.
    logic signed [W-1:0]     zr_reg, zi_reg, z2r_reg, z2i_reg, tr_reg, ti_reg;
    logic signed [W-1:0]     ur_reg, ui_reg, vr_reg, vi_reg, nr_reg, ni_reg;
    logic signed [W-1:0]     dr_reg, di_reg, mt_reg;
    logic signed [2*W-1:0]   prod_reg;
    logic signed [AW-1:0]    acc_reg, num_re_reg, num_im_reg;
    logic [2*W-1:0]          den_reg;

    // Root under test and distance terms.
    logic signed [W-1:0] root_re, root_im, fr, fi, w_re;
    always_comb
    begin
        case (cmd.root_sel)
            ROOT_MINUS_ONE:
            begin
                root_re = MONE_W;
                root_im = '0;
            end
            ROOT_B:
            begin
                root_re = clamp32(bre_reg);
                root_im = clamp32(bim_reg);
            end
            default:
            begin
                root_re = clamp32(cre_reg);
                root_im = clamp32(cim_reg);
            end
        endcase
    end
    assign fr   = sat_sub(zr_reg, root_re);
    assign fi   = sat_sub(zi_reg, root_im);
    assign w_re = sat_add(zr_reg, ONE_W);

    // Operand selection for the shared multiplier.
    logic signed [W-1:0]   ma, mb;
    logic signed [2*W-1:0] prod_next;
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.mul_sel)
            M_FR_FR:  begin ma = fr;     mb = fr;      end
            M_FI_FI:  begin ma = fi;     mb = fi;      end
            M_ZR_ZR:  begin ma = zr_reg; mb = zr_reg;  end
            M_ZI_ZI:  begin ma = zi_reg; mb = zi_reg;  end
            M_ZR_ZI:  begin ma = zr_reg; mb = zi_reg;  end
            M_ZI_ZR:  begin ma = zi_reg; mb = zr_reg;  end
            M_W_Z2R:  begin ma = w_re;   mb = z2r_reg; end
            M_ZI_Z2I: begin ma = zi_reg; mb = z2i_reg; end
            M_W_Z2I:  begin ma = w_re;   mb = z2i_reg; end
            M_ZI_Z2R: begin ma = zi_reg; mb = z2r_reg; end
            M_UR_ZR:  begin ma = ur_reg; mb = zr_reg;  end
            M_UI_ZI:  begin ma = ui_reg; mb = zi_reg;  end
            M_UR_ZI:  begin ma = ur_reg; mb = zi_reg;  end
            M_UI_ZR:  begin ma = ui_reg; mb = zr_reg;  end
            M_DR_DR:  begin ma = dr_reg; mb = dr_reg;  end
            M_DI_DI:  begin ma = di_reg; mb = di_reg;  end
            M_NR_DR:  begin ma = nr_reg; mb = dr_reg;  end
            M_NI_DI:  begin ma = ni_reg; mb = di_reg;  end
            M_NI_DR:  begin ma = ni_reg; mb = dr_reg;  end
            M_NR_DI:  begin ma = nr_reg; mb = di_reg;  end
            default:  begin ma = '0;     mb = '0;      end
        endcase
    end
    assign prod_next = ma * mb;

    // Scaled product and exact sums taken from the registered product.
    logic signed [W-1:0]  mq;
    logic signed [AW-1:0] prod_ext, acc_sum, acc_dif;
    assign mq       = mulq(prod_reg);
    assign prod_ext = AW'(prod_reg);
    assign acc_sum  = acc_reg + prod_ext;
    assign acc_dif  = acc_reg - prod_ext;

    // Dividers for the real and imaginary quotient.
    logic                done_re, done_im;
    logic signed [W-1:0] quo_re, quo_im;

    nfb_div #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_re (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_re_reg),
        .den   (den_reg),
        .done  (done_re),
        .quo   (quo_re)
    );

    nfb_div #(.WORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_im (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_im_reg),
        .den   (den_reg),
        .done  (done_im),
        .quo   (quo_im)
    );

    // Register updates driven by the command.
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.load)
        begin
            zr_reg <= clamp32(start_re);
            zi_reg <= clamp32(start_im);
        end
        else if (done_re)
        begin
            zr_reg <= quo_re;
            zi_reg <= quo_im;
        end
        case (cmd.post)
            P_LATCH_U:
            begin
                ur_reg <= sat_add(sat_add(sat_add(zr_reg, zr_reg), zr_reg), FOUR_W);
                ui_reg <= sat_add(sat_add(zi_reg, zi_reg), zi_reg);
            end
            P_ACC_LD:  acc_reg <= prod_ext;
            P_ACC_ADD: acc_reg <= acc_sum;
            P_MT:      mt_reg  <= mq;
            P_Z2R:     z2r_reg <= sat_sub(mt_reg, mq);
            P_Z2I:     z2i_reg <= sat_add(mt_reg, mq);
            P_TR:      tr_reg  <= sat_sub(mt_reg, mq);
            P_TI:      ti_reg  <= sat_add(mt_reg, mq);
            P_VR:      vr_reg  <= sat_sub(mt_reg, mq);
            P_VI_N:
            begin
                vi_reg <= sat_add(mt_reg, mq);
                nr_reg <= sat_sub(sat_add(tr_reg, tr_reg), alpha_w);
                ni_reg <= sat_add(ti_reg, ti_reg);
            end
            P_D:
            begin
                dr_reg <= sat_add(sat_add(vr_reg, alpha_w), ONE_W);
                di_reg <= vi_reg;
            end
            P_DEN:     den_reg    <= acc_sum[2*W-1:0];
            P_NUM_RE:  num_re_reg <= acc_sum;
            P_NUM_IM:  num_im_reg <= acc_dif;
            default: ;
        endcase
    end

    // Status: capture test, zero denominator, divider finished, step limit.
    logic [CMPW-1:0] d2_ext, cap_ext;
    assign d2_ext  = CMPW'(acc_reg[2*W-1:0]);
    assign cap_ext = CMPW'(hit_reg) << FRAC_BITS;

    assign stat.hit        = d2_ext < cap_ext;
    assign stat.den_zero   = (dr_reg == '0) && (di_reg == '0);
    assign stat.div_done   = done_re && done_im;
    assign stat.step_limit = limit_reg;

endmodule

### rtl/nfb_ctrl.sv
// Controller: sequences root tests, Newton steps and divisions, and holds the result register.
// Depends on nfb_pkg.
module nfb_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    root_index,
    output logic [nfb_pkg::COUNT_W-1:0]   iteration_count,
    output nfb_pkg::dp_cmd_t              cmd,
    input  nfb_pkg::dp_stat_t             stat
);
    import nfb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_TEST = 5'b00010,
        S_ITER = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [UC_W-1:0]    uc_reg, uc_next;
    logic [1:0]         k_reg, k_next;
    logic [COUNT_W-1:0] i_reg, i_next;
    logic [1:0]         res_idx_reg, res_idx_next;
    logic [COUNT_W-1:0] res_cnt_reg, res_cnt_next;
    logic               ov_reg, ov_next;
    logic [1:0]         oidx_reg, oidx_next;
    logic [COUNT_W-1:0] ocnt_reg, ocnt_next;
    uop_t               uop;

    assign uop = iter_uop(uc_reg);

    // Next-state and command logic.
    always_comb
    begin
        state_next   = state_reg;
        uc_next      = uc_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        res_idx_next = res_idx_reg;
        res_cnt_next = res_cnt_reg;
        ov_next      = ov_reg && !out_ready;
        oidx_next    = oidx_reg;
        ocnt_next    = ocnt_reg;
        cmd          = '{load: 1'b0, mul_sel: M_NONE, post: P_NONE,
                         root_sel: k_reg, div_start: 1'b0};
        in_ready     = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    i_next     = '0;
                    k_next     = ROOT_MINUS_ONE;
                    uc_next    = '0;
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (uc_reg == TEST_MUL_FR && k_reg == ROOT_MINUS_ONE
                    && i_reg == stat.step_limit)
                begin
                    res_idx_next = ROOT_NONE;
                    res_cnt_next = i_reg;
                    state_next   = S_DONE;
                end
                else
                begin
                    case (uc_reg)
                        TEST_MUL_FR: cmd.mul_sel = M_FR_FR;
                        TEST_MUL_FI:
                        begin
                            cmd.mul_sel = M_FI_FI;
                            cmd.post    = P_ACC_LD;
                        end
                        TEST_SUM:    cmd.post = P_ACC_ADD;
                        default: ;
                    endcase
                    if (uc_reg == TEST_LAST)
                    begin
                        uc_next = '0;
                        if (stat.hit)
                        begin
                            res_idx_next = k_reg;
                            res_cnt_next = i_reg;
                            state_next   = S_DONE;
                        end
                        else if (k_reg == ROOT_C)
                        begin
                            state_next = S_ITER;
                        end
                        else
                        begin
                            k_next = k_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        uc_next = uc_reg + 1'b1;
                    end
                end
            end
            S_ITER:
            begin
                cmd.mul_sel = uop.mul_sel;
                cmd.post    = uop.post;
                if (uc_reg == ITER_ZCHK && stat.den_zero)
                begin
                    res_idx_next = ROOT_NONE;
                    res_cnt_next = stat.step_limit;
                    state_next   = S_DONE;
                end
                else if (uc_reg == ITER_LAST)
                begin
                    uc_next    = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    uc_next = uc_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                if (uc_reg == '0)
                begin
                    cmd.div_start = 1'b1;
                    uc_next       = UC_W'(1);
                end
                else if (stat.div_done)
                begin
                    i_next     = i_reg + 1'b1;
                    k_next     = ROOT_MINUS_ONE;
                    uc_next    = '0;
                    state_next = S_TEST;
                end
            end
            S_DONE:
            begin
                // Move the result to the output register once it is free.
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    oidx_next  = res_idx_reg;
                    ocnt_next  = res_cnt_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            uc_reg    <= '0;
            k_reg     <= '0;
            i_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            uc_reg    <= uc_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            ov_reg    <= ov_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        res_idx_reg <= res_idx_next;
        res_cnt_reg <= res_cnt_next;
        oidx_reg    <= oidx_next;
        ocnt_reg    <= ocnt_next;
    end

    assign out_valid       = ov_reg;
    assign root_index      = oidx_reg;
    assign iteration_count = ocnt_reg;

endmodule

### rtl/newton_fractal_basin_core.sv
// Newton basin classifier for z^3 + 2z^2 + (a+1)z + a, one start point at a time.
// Each step runs the root tests, the multiplier sequence and then the division; a run ends
// when a root captures the point, when the step limit N is reached, or on a zero denominator.
// The next point is taken only once the last one has finished, also while its result waits.
// Reset: rst_n is asynchronous, active low; configuration and control registers return to their reset values.
// Depends on nfb_pkg, nfb_ctrl and nfb_datapath.
module newton_fractal_basin_core #(
    parameter int WORD_WIDTH = nfb_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = nfb_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nfb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                       cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [31:0]                start_re,
    input  logic signed [31:0]                start_im,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        root_index,
    output logic [nfb_pkg::COUNT_W-1:0]       iteration_count
);
    import nfb_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    nfb_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .root_index      (root_index),
        .iteration_count (iteration_count),
        .cmd             (cmd),
        .stat            (stat)
    );

    nfb_datapath #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start_re  (start_re),
        .start_im  (start_im),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

### rtl/nfb_checker.sv
// Port-level checks for the Newton basin core, attached by a bind statement.
// Depends on the ports of newton_fractal_basin_core only.
module nfb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [2:0]  cfg_index,
    input logic [31:0] cfg_data,
    input logic        in_valid,
    input logic        in_ready,
    input logic [31:0] start_re,
    input logic [31:0] start_im,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  root_index,
    input logic [9:0]  iteration_count
);
    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(root_index)
                                    && $stable(iteration_count))
        else $error("result changed while stalled");

    // After a point is taken the core is not ready in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again straight after a transfer");

    // A new result only appears while the core is working on a point.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while the core was idle");

endmodule

bind newton_fractal_basin_core nfb_checker u_nfb_checker (.*);
